### hdl/lrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants for the log record deframer with CRC check.
// ----------------------------------------------------------------------------
package lrd_pkg;

   localparam int unsigned PosWidth    = 18;
   localparam int unsigned HeaderBytes = 34;

   localparam logic [31:0] CrcInit      = 32'hFFFF_FFFF;
   localparam logic [31:0] CrcPolyReset = 32'h82F6_3B78;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [63:0] sequence_number;
      logic [63:0] previous_sequence;
      logic [63:0] transaction_id;
      logic [31:0] page_number;
      logic [7:0]  record_kind;
      logic [15:0] redo_length;
      logic [15:0] undo_length;
   } header_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       payload_is_undo;
      header_type hdr;
   } result_type;

endpackage

### hdl/lrd_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_crc_byte
// Reflected CRC-32 update by one byte with a programmable polynomial.
// ----------------------------------------------------------------------------
module lrd_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   input  logic [31:0] polynomial,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         c = {1'b0, c[31:1]} ^ (polynomial & {32{c[0]}});
      end
      crc_next = c;
   end

endmodule

### hdl/lrd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_parser
// Record parser: header capture, payload pass-through, CRC accumulate and
// verdict. State changes only on accepted input beats; none while halted.
// ----------------------------------------------------------------------------
module lrd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                start_of_log,
   input  logic [31:0]         polynomial,
   output logic                res_valid,
   output lrd_pkg::result_type res
);
   import lrd_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in, pos;
   logic [31:0]         crc_ff, crc_in, crc_cur, crc_next;
   logic [31:0]         rcv_ff, rcv_in, rcv_cur, rcv_merge;
   logic                halted_ff, halted_in, halt_eff;
   header_type          hdr_ff, hdr_in;
   logic [PosWidth-1:0] redo_end, pay_end;
   logic [5:0]          pos6;
   logic [1:0]          k;
   logic                in_header, in_payload, ok;

   lrd_crc_byte u_crc (
      .crc_cur    (crc_cur),
      .data_byte  (data_byte),
      .polynomial (polynomial),
      .crc_next   (crc_next)
   );

   always_comb begin
      halt_eff   = halted_ff && !start_of_log;
      pos        = start_of_log ? '0 : pos_ff;
      crc_cur    = start_of_log ? CrcInit : crc_ff;
      rcv_cur    = start_of_log ? '0 : rcv_ff;
      pos6       = pos[5:0];
      in_header  = pos < PosWidth'(HeaderBytes);
      redo_end   = PosWidth'(HeaderBytes) + PosWidth'(hdr_ff.redo_length);
      pay_end    = redo_end + PosWidth'(hdr_ff.undo_length);
      in_payload = !in_header && (pos < pay_end);
      k          = pos[1:0] - pay_end[1:0];
      rcv_merge  = rcv_cur;
      rcv_merge[{k, 3'b000} +: 8] = data_byte;
      ok         = (crc_cur ^ CrcInit) == rcv_merge;

      pos_in    = pos_ff;
      crc_in    = crc_ff;
      rcv_in    = rcv_ff;
      halted_in = halted_ff;
      hdr_in    = hdr_ff;
      res_valid = 1'b0;
      res       = '0;

      if (take) begin
         halted_in = halt_eff;
         pos_in    = pos;
         crc_in    = crc_cur;
         rcv_in    = rcv_cur;
         if (!halt_eff) begin
            if (in_header) begin
               if (pos6 < 6'd8) begin
                  hdr_in.sequence_number[{pos6[2:0], 3'b000} +: 8] = data_byte;
               end else if (pos6 < 6'd16) begin
                  hdr_in.previous_sequence[{pos6[2:0], 3'b000} +: 8] = data_byte;
               end else if (pos6 < 6'd24) begin
                  hdr_in.transaction_id[{pos6[2:0], 3'b000} +: 8] = data_byte;
               end else if (pos6 < 6'd28) begin
                  hdr_in.page_number[{pos6[1:0], 3'b000} +: 8] = data_byte;
               end else if (pos6 == 6'd28) begin
                  hdr_in.record_kind = data_byte;
               end else if (pos6 == 6'd29) begin
                  hdr_in.redo_length[7:0] = data_byte;
               end else if (pos6 == 6'd30) begin
                  hdr_in.redo_length[15:8] = data_byte;
               end else if (pos6 == 6'd31) begin
                  hdr_in.undo_length[7:0] = data_byte;
               end else if (pos6 == 6'd32) begin
                  hdr_in.undo_length[15:8] = data_byte;
               end
               crc_in = crc_next;
               pos_in = pos + 1'b1;
            end else if (in_payload) begin
               crc_in              = crc_next;
               pos_in              = pos + 1'b1;
               res_valid           = 1'b1;
               res.kind            = KIND_PAYLOAD;
               res.payload_byte    = data_byte;
               res.payload_is_undo = pos >= redo_end;
            end else begin
               rcv_in = rcv_merge;
               if (k != 2'd3) begin
                  pos_in = pos + 1'b1;
               end else begin
                  res_valid = 1'b1;
                  res.kind  = ok ? KIND_ACCEPT : KIND_REJECT;
                  res.hdr   = hdr_ff;
                  halted_in = !ok;
                  pos_in    = '0;
                  crc_in    = CrcInit;
                  rcv_in    = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= CrcInit;
         rcv_ff    <= '0;
         halted_ff <= 1'b0;
         hdr_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         rcv_ff    <= rcv_in;
         halted_ff <= halted_in;
         hdr_ff    <= hdr_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (take && halted_ff && !start_of_log) |-> !res_valid)
      else $error("result issued while halted");

   a_verdict_restart: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind != KIND_PAYLOAD) |=> (pos_ff == '0 && crc_ff == CrcInit))
      else $error("record state not restarted after verdict");

   a_reject_halts: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_REJECT) |=> halted_ff)
      else $error("reject did not halt parser");

endmodule

### hdl/lrd_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_out_skid
// Output register with one skid entry so the parser keeps taking beats
// while a result waits at the output.
// ----------------------------------------------------------------------------
module lrd_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lrd_pkg::result_type in_data,
   output logic                up_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output lrd_pkg::result_type out_data
);
   import lrd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign up_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !in_valid)
      else $error("result offered while skid full");

endmodule

### hdl/log_record_deframer_crc_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_deframer_crc_check_core
// Parses a log byte stream into records and checks each record's CRC-32C.
//
// Input channel (req_*): one log byte per beat; req_start_of_log restarts
// the parser with this byte as header byte 0 and clears a halt.
// Result channel (rsp_*): one beat per payload byte (kind payload, with
// redo/undo flag), and one beat per record at its last CRC byte carrying
// the header fields with an accept or reject verdict. Header and CRC bytes
// give no result. After a reject all bytes are dropped until start of log.
// CSR channel (csr_*): writes the reflected CRC polynomial, always ready;
// write only while the block is idle.
// Throughput: one byte per cycle while req_ready is high; the byte-wide CRC update and position
// compare sit between the parser state and the output register.
// Each result is registered at the output (via the skid entry if it is busy).
// Reset: polynomial returns to 0x82F63B78, parser at header byte 0.
// Stall: a one-entry skid holds one result while rsp_ready is low; once
// it fills, req_ready drops until the output drains.
// ----------------------------------------------------------------------------
module log_record_deframer_crc_check_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_log,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_is_undo,
   output logic [63:0] rsp_sequence_number,
   output logic [63:0] rsp_previous_sequence,
   output logic [63:0] rsp_transaction_id,
   output logic [31:0] rsp_page_number,
   output logic [7:0]  rsp_record_kind,
   output logic [15:0] rsp_redo_length,
   output logic [15:0] rsp_undo_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_crc_polynomial
);
   import lrd_pkg::*;

   logic [31:0] poly_ff;
   logic        take;
   logic        res_valid;
   result_type  res;
   result_type  out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= CrcPolyReset;
      end else if (csr_valid && csr_ready) begin
         poly_ff <= csr_crc_polynomial;
      end
   end

   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;

   lrd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_data_byte),
      .start_of_log (req_start_of_log),
      .polynomial   (poly_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   lrd_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .up_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_result_kind       = out_data.kind;
   assign rsp_payload_byte      = out_data.payload_byte;
   assign rsp_payload_is_undo   = out_data.payload_is_undo;
   assign rsp_sequence_number   = out_data.hdr.sequence_number;
   assign rsp_previous_sequence = out_data.hdr.previous_sequence;
   assign rsp_transaction_id    = out_data.hdr.transaction_id;
   assign rsp_page_number       = out_data.hdr.page_number;
   assign rsp_record_kind       = out_data.hdr.record_kind;
   assign rsp_redo_length       = out_data.hdr.redo_length;
   assign rsp_undo_length       = out_data.hdr.undo_length;

endmodule

### tb/lrd_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrd_record_checker
// Watches the byte, result and CSR channels of the log record deframer.
// Every accepted byte runs through a local parser with its own CRC state;
// payload bytes and record verdicts it predicts are queued and compared
// field by field against the result beats in order.
// ----------------------------------------------------------------------------
module lrd_record_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_log,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_result_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_payload_is_undo,
   input  logic [63:0] rsp_sequence_number,
   input  logic [63:0] rsp_previous_sequence,
   input  logic [63:0] rsp_transaction_id,
   input  logic [31:0] rsp_page_number,
   input  logic [7:0]  rsp_record_kind,
   input  logic [15:0] rsp_redo_length,
   input  logic [15:0] rsp_undo_length,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_crc_polynomial,
   output int          fail_count,
   output int          pending
);
   import lrd_pkg::*;

   logic [31:0]  crc_poly;
   logic [17:0]  parse_pos;
   header_type   held_hdr;
   logic [31:0]  crc_acc;
   logic [31:0]  crc_stored;
   logic         dropping;
   result_type   predicted_results [$];

   function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b,
                                            input logic [31:0] p);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? p : 32'd0);
      return r;
   endfunction

   task automatic restart_record();
      parse_pos  = '0;
      crc_acc    = CrcInit;
      crc_stored = '0;
   endtask

   task automatic store_header_byte(input int p, input logic [7:0] b);
      if (p < 8) held_hdr.sequence_number[p*8 +: 8] = b;
      else if (p < 16) held_hdr.previous_sequence[(p-8)*8 +: 8] = b;
      else if (p < 24) held_hdr.transaction_id[(p-16)*8 +: 8] = b;
      else if (p < 28) held_hdr.page_number[(p-24)*8 +: 8] = b;
      else if (p == 28) held_hdr.record_kind = b;
      else if (p < 31) held_hdr.redo_length[(p-29)*8 +: 8] = b;
      else if (p < 33) held_hdr.undo_length[(p-31)*8 +: 8] = b;
   endtask

   task automatic parse_log_byte(input logic [7:0] b, input logic sol);
      int p, redo_end, pay_end, k;
      result_type r;
      if (sol) begin
         dropping = 1'b0;
         restart_record();
      end
      if (dropping) return;
      p = int'(parse_pos);
      if (p < HeaderBytes) begin
         store_header_byte(p, b);
         crc_acc   = crc_fold(crc_acc, b, crc_poly);
         parse_pos = 18'(p + 1);
         return;
      end
      redo_end = HeaderBytes + held_hdr.redo_length;
      pay_end  = redo_end + held_hdr.undo_length;
      r = '0;
      if (p < pay_end) begin
         crc_acc           = crc_fold(crc_acc, b, crc_poly);
         parse_pos         = 18'(p + 1);
         r.kind            = KIND_PAYLOAD;
         r.payload_byte    = b;
         r.payload_is_undo = (p >= redo_end);
         predicted_results.insert(predicted_results.size(), r);
         return;
      end
      k = (p - pay_end) & 3;
      crc_stored[k*8 +: 8] = b;
      if (k < 3) begin
         parse_pos = 18'(p + 1);
         return;
      end
      r.kind = ((crc_acc ^ CrcInit) == crc_stored) ? KIND_ACCEPT : KIND_REJECT;
      r.hdr  = held_hdr;
      if (r.kind == KIND_REJECT) dropping = 1'b1;
      restart_record();
      predicted_results.insert(predicted_results.size(), r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0h, actual %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         crc_poly = CrcPolyReset;
         held_hdr = '0;
         dropping = 1'b0;
         restart_record();
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) crc_poly = csr_crc_polynomial;
         if (req_valid && req_ready) parse_log_byte(req_data_byte, req_start_of_log);
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               fail_count++;
               $error("unexpected result beat, kind %0d", rsp_result_kind);
            end else begin
               want = predicted_results.pop_front();
               check_field("result_kind", 64'(want.kind), 64'(rsp_result_kind));
               check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_payload_byte));
               check_field("payload_is_undo", 64'(want.payload_is_undo),
                           64'(rsp_payload_is_undo));
               check_field("sequence_number", want.hdr.sequence_number, rsp_sequence_number);
               check_field("previous_sequence", want.hdr.previous_sequence,
                           rsp_previous_sequence);
               check_field("transaction_id", want.hdr.transaction_id, rsp_transaction_id);
               check_field("page_number", 64'(want.hdr.page_number), 64'(rsp_page_number));
               check_field("record_kind", 64'(want.hdr.record_kind), 64'(rsp_record_kind));
               check_field("redo_length", 64'(want.hdr.redo_length), 64'(rsp_redo_length));
               check_field("undo_length", 64'(want.hdr.undo_length), 64'(rsp_undo_length));
            end
         end
      end
      pending <= predicted_results.size();
   end

endmodule

### tb/tb_log_record_deframer_crc_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_record_deframer_crc_check_core
// Drives framed log records into the deframer: good records, bad CRCs,
// records cut off by a new log start, and junk, under several polynomials
// and random stalls on both channels. The checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_crc_check_core;
   import lrd_pkg::*;

   localparam int CycleLimit = 2_000_000;
   localparam int HoldCycles = 300;
   localparam int FillRandom = 0;
   localparam int FillZero   = 1;
   localparam int FillOnes   = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_start_of_log = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_is_undo;
   logic [63:0] rsp_sequence_number;
   logic [63:0] rsp_previous_sequence;
   logic [63:0] rsp_transaction_id;
   logic [31:0] rsp_page_number;
   logic [7:0]  rsp_record_kind;
   logic [15:0] rsp_redo_length;
   logic [15:0] rsp_undo_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_crc_polynomial = 32'd0;

   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          rsp_stall = 0;
   int          stream_bytes = 0;
   int          records_closed = 0;
   logic        quiet = 1'b0;
   logic        hold_go = 1'b0;
   logic        rsp_hold = 1'b0;
   logic        in_sync = 1'b0;
   logic [31:0] gen_poly = CrcPolyReset;

   log_record_deframer_crc_check_core u_dut (.*);

   lrd_record_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall <= pick_gap();
      end
   end

   // long receiver hold-off; the sender keeps going and the block backs up
   initial begin
      wait (hold_go);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic logic [31:0] frame_crc_byte(input logic [31:0] c, input logic [7:0] b,
                                                  input logic [31:0] p);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? p : 32'd0);
      return r;
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 35) return 16'd0;
      if (r < 85) return 16'($urandom_range(12, 1));
      if (r < 97) return 16'($urandom_range(40, 13));
      return 16'($urandom_range(120, 41));
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic sol);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_start_of_log <= sol;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_noise(input int n, input logic allow_sol);
      for (int i = 0; i < n; i++) begin
         send_beat(8'($urandom), allow_sol && ($urandom_range(3) == 0));
         if (allow_sol) stream_bytes++;
      end
      if (allow_sol) in_sync = 1'b0;
   endtask

   // cut < 0 sends the whole record; otherwise stops before byte index cut
   task automatic send_record(input logic [15:0] redo_bytes, input logic [15:0] undo_bytes,
                              input int fill, input int cut, input logic bad_crc);
      logic [7:0]  head [HeaderBytes];
      logic [31:0] crc;
      logic [31:0] stored;
      logic [7:0]  b;
      logic        sol;
      int          total;
      int          flip;
      for (int i = 0; i < HeaderBytes; i++)
         head[i] = (fill == FillZero) ? 8'h00 : (fill == FillOnes) ? 8'hFF : 8'($urandom);
      {head[30], head[29]} = redo_bytes;
      {head[32], head[31]} = undo_bytes;
      sol    = !in_sync || ($urandom_range(7) == 0);
      total  = HeaderBytes + redo_bytes + undo_bytes;
      crc    = CrcInit;
      stored = '0;
      for (int i = 0; i < total + 4; i++) begin
         if (i == cut) begin
            in_sync = 1'b0;
            return;
         end
         if (i < HeaderBytes) b = head[i];
         else if (i < total) b = 8'($urandom);
         else b = stored[(i - total) * 8 +: 8];
         if (i < total) crc = frame_crc_byte(crc, b, gen_poly);
         if (i == total - 1) begin
            stored = crc ^ CrcInit;
            if (bad_crc) begin
               flip = $urandom_range(31);
               stored[flip] = ~stored[flip];
            end
         end
         send_beat(b, (i == 0) && sol);
         stream_bytes++;
      end
      in_sync = !bad_crc;
      records_closed++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_poly(input logic [31:0] value);
      csr_valid          <= 1'b1;
      csr_crc_polynomial <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gen_poly = value;
   endtask

   task automatic run_mix(input int byte_goal, input int record_goal);
      int          first_bytes;
      int          first_records;
      int          r;
      logic [15:0] rl;
      logic [15:0] ul;
      first_bytes   = stream_bytes;
      first_records = records_closed;
      while (stream_bytes - first_bytes < byte_goal ||
             records_closed - first_records < record_goal) begin
         quiet = ($urandom_range(7) == 0);
         rl = pick_len();
         ul = pick_len();
         r  = $urandom_range(99);
         if (r < 70) begin
            send_record(rl, ul, FillRandom, -1, 1'b0);
         end else if (r < 82) begin
            send_record(rl, ul, FillRandom, -1, 1'b1);
            if ($urandom_range(1)) send_noise($urandom_range(6, 1), 1'b0);
         end else if (r < 94) begin
            send_record(rl, ul, FillRandom, $urandom_range(HeaderBytes + rl + ul + 3, 1),
                        1'b0);
         end else begin
            send_noise($urandom_range(12, 1), 1'b1);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      logic [31:0] poly_plan [5];
      poly_plan = '{CrcPolyReset, 32'h0000_0000, 32'hFFFF_FFFF, 32'hEDB8_8320, 32'h0};
      poly_plan[4] = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed records under the reset polynomial
      send_record(16'd0, 16'd0, FillZero, -1, 1'b0);
      send_record(16'd1, 16'd1, FillOnes, -1, 1'b0);
      send_record(16'd3, 16'd0, FillRandom, HeaderBytes + 2, 1'b0);
      send_record(16'd0, 16'd2, FillRandom, HeaderBytes + 3, 1'b0);
      send_record(16'd5, 16'd5, FillRandom, 10, 1'b0);
      send_record(16'hFFFF, 16'hFFFF, FillRandom, HeaderBytes + 4, 1'b0);
      send_record(16'd2, 16'd1, FillRandom, -1, 1'b1);
      send_noise(5, 1'b0);
      send_record(16'd0, 16'd0, FillRandom, -1, 1'b0);
      send_record(16'd2, 16'd3, FillRandom, -1, 1'b0);
      settle();

      foreach (poly_plan[i]) begin
         write_poly(poly_plan[i]);
         if (i == 0) begin
            hold_go = 1'b1;
            send_record(16'd60, 16'd20, FillRandom, -1, 1'b0);
         end
         run_mix(40, 1);
         settle();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### log_record_deframer_crc_check_core.f
hdl/lrd_pkg.sv
hdl/lrd_crc_byte.sv
hdl/lrd_parser.sv
hdl/lrd_out_skid.sv
hdl/log_record_deframer_crc_check_core.sv
tb/lrd_record_checker.sv
tb/tb_log_record_deframer_crc_check_core.sv
